[rtl/drt_pkg.sv]
// ---------------------------------------------------------------------------
// drt_pkg
// Shared types and constants for the device record table.
// ---------------------------------------------------------------------------
package drt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = 48;
   localparam int AGE_W = 32;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_SETBOND = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic [1:0] BOND_UNKNOWN = 2'd0;
   localparam logic [1:0] BOND_BAD     = 2'd3;

   localparam logic [7:0] KEY_AUTH_A = 8'd5;
   localparam logic [7:0] KEY_AUTH_B = 8'd8;
   localparam logic [4:0] PIN_AUTH_MIN = 5'd16;

   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] peer_address;
      logic              has_link_key;
      logic [7:0]        link_key_kind;
      logic [4:0]        pin_digits;
      logic              link_active;
      logic [1:0]        new_bond_type;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              was_found;
      logic [3:0]        slot_index;
      logic              did_evict;
      logic [ADDR_W-1:0] evicted_address;
      logic              is_paired;
      logic              is_authenticated;
      logic [1:0]        bond_kind;
   } rsp_type;

   // one stored record (valid kept in flops elsewhere)
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [AGE_W-1:0]  age;
      logic              paired;
      logic              authenticated;
      logic [7:0]        stored_key;
      logic [1:0]        bond;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

[rtl/drt_ram.sv]
// ---------------------------------------------------------------------------
// drt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module drt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/drt_scan.sv]
// ---------------------------------------------------------------------------
// drt_scan
// Sequencer: scans the record RAM one slot a cycle for a match, a free slot
// and the oldest victims, then writes back on add, lookup or a set-bond hit.
// ---------------------------------------------------------------------------
module drt_scan import drt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  req_type                  req,
   output logic                     busy,
   output logic                     done,
   output rsp_type                  rsp,
   output logic                     ram_we,
   output logic [SLOT_W-1:0]        ram_waddr,
   output rec_type                  ram_wdata,
   output logic [SLOT_W-1:0]        ram_raddr,
   input  rec_type                  ram_rdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_FETCH = 5'b00100,
      S_WAIT  = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;   // addresses issued
   logic [CNT_W-1:0]  chk_cnt_ff, chk_cnt_in; // records checked
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [AGE_W-1:0]  age_ctr_ff, age_ctr_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_ff_idx, hit_idx_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic              vu_ff, vu_in, vp_ff, vp_in;
   logic [SLOT_W-1:0] vu_idx_ff, vu_idx_in, vp_idx_ff, vp_idx_in;
   logic [AGE_W-1:0]  vu_age_ff, vu_age_in, vp_age_ff, vp_age_in;
   rsp_type           rsp_in;
   logic [SLOT_W-1:0] chk_idx;
   logic [SLOT_W-1:0] tgt;
   logic              alloc;
   rec_type           rec;
   logic              we;
   logic [SLOT_W-1:0] raddr;

   assign chk_idx = chk_cnt_ff[SLOT_W-1:0];
   assign busy    = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      rd_cnt_in   = rd_cnt_ff;
      chk_cnt_in  = chk_cnt_ff;
      valid_in    = valid_ff;
      age_ctr_in  = age_ctr_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_ff_idx;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      vu_in = vu_ff; vu_idx_in = vu_idx_ff; vu_age_in = vu_age_ff;
      vp_in = vp_ff; vp_idx_in = vp_idx_ff; vp_age_in = vp_age_ff;
      rsp_in = rsp;
      we     = 1'b0;
      rec    = ram_rdata;
      raddr  = rd_cnt_ff[SLOT_W-1:0];
      tgt    = hit_ff_idx;
      alloc  = 1'b0;
      done   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            raddr = '0;
            if (start) begin
               state_in   = S_SCAN;
               rd_cnt_in  = CNT_W'(1);
               chk_cnt_in = '0;
               hit_in = 1'b0; free_in = 1'b0; vu_in = 1'b0; vp_in = 1'b0;
            end
         end
         S_SCAN: begin
            // ram_rdata holds slot chk_idx
            if (!hit_ff) begin
               if (valid_ff[chk_idx]) begin
                  if (ram_rdata.address == req_ff.peer_address) begin
                     hit_in = 1'b1; hit_idx_in = chk_idx;
                  end
                  if (ram_rdata.paired) begin
                     if (!vp_ff || ram_rdata.age < vp_age_ff) begin
                        vp_in = 1'b1; vp_idx_in = chk_idx; vp_age_in = ram_rdata.age;
                     end
                  end else if (!vu_ff || ram_rdata.age < vu_age_ff) begin
                     vu_in = 1'b1; vu_idx_in = chk_idx; vu_age_in = ram_rdata.age;
                  end
               end else if (!free_ff) begin
                  free_in = 1'b1; free_idx_in = chk_idx;
               end
            end
            chk_cnt_in = chk_cnt_ff + CNT_W'(1);
            if (rd_cnt_ff != CNT_W'(TABLE_ENTRIES)) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            if (chk_cnt_ff == CNT_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (hit_ff) tgt = hit_ff_idx;
            else if (free_ff) tgt = free_idx_ff;
            else if (vu_ff) tgt = vu_idx_ff;
            else tgt = vp_idx_ff;
            raddr = tgt;
            hit_idx_in = tgt;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            // keep the target record on the read port
            raddr = hit_ff_idx;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            tgt   = hit_ff_idx;
            alloc = !hit_ff;
            rsp_in = '0;
            state_in = S_IDLE;
            done = 1'b1;
            case (req_ff.operation)
               OP_ADD, OP_LOOKUP: begin
                  if (alloc) begin
                     rec.address = req_ff.peer_address;
                     rec.age = age_ctr_ff;
                     rec.paired = 1'b0;
                     rec.authenticated = 1'b0;
                     rec.stored_key = '0;
                     rec.bond = BOND_UNKNOWN;
                     age_ctr_in = age_ctr_ff + AGE_W'(1);
                     rsp_in.did_evict = !free_ff;
                     rsp_in.evicted_address = free_ff ? '0 : ram_rdata.address;
                  end else if (req_ff.operation == OP_ADD) begin
                     rec.age = age_ctr_ff;
                     rec.bond = BOND_UNKNOWN;
                     age_ctr_in = age_ctr_ff + AGE_W'(1);
                  end
                  if (req_ff.operation == OP_ADD && req_ff.has_link_key) begin
                     rec.paired = 1'b1;
                     rec.stored_key = req_ff.link_key_kind;
                     if (req_ff.pin_digits >= PIN_AUTH_MIN ||
                         req_ff.link_key_kind == KEY_AUTH_A ||
                         req_ff.link_key_kind == KEY_AUTH_B) begin
                        rec.authenticated = 1'b1;
                     end
                  end
                  we = 1'b1;
                  valid_in[tgt] = 1'b1;
                  rsp_in.was_found = hit_ff;
                  rsp_in.slot_index = 4'(tgt);
                  rsp_in.is_paired = rec.paired;
                  rsp_in.is_authenticated = rec.authenticated;
                  rsp_in.bond_kind = rec.bond;
               end
               OP_DELETE: begin
                  if (req_ff.link_active) begin
                     rsp_in.status = ST_REFUSED;
                  end else if (hit_ff) begin
                     valid_in[tgt] = 1'b0;
                     rsp_in.was_found = 1'b1;
                     rsp_in.slot_index = 4'(tgt);
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     rsp_in.status = ST_UNKNOWN;
                  end else begin
                     rec.bond = (req_ff.new_bond_type == BOND_BAD) ? BOND_UNKNOWN
                                                                  : req_ff.new_bond_type;
                     we = 1'b1;
                     rsp_in.was_found = 1'b1;
                     rsp_in.slot_index = 4'(tgt);
                     rsp_in.is_paired = rec.paired;
                     rsp_in.is_authenticated = rec.authenticated;
                     rsp_in.bond_kind = rec.bond;
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ram_we    = we;
   assign ram_waddr = tgt;
   assign ram_wdata = rec;
   assign ram_raddr = raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         age_ctr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         age_ctr_ff <= age_ctr_in;
      end
      if (start && state_ff == S_IDLE) req_ff <= req;
      rd_cnt_ff  <= rd_cnt_in;
      chk_cnt_ff <= chk_cnt_in;
      hit_ff <= hit_in; hit_ff_idx <= hit_idx_in;
      free_ff <= free_in; free_idx_ff <= free_idx_in;
      vu_ff <= vu_in; vu_idx_ff <= vu_idx_in; vu_age_ff <= vu_age_in;
      vp_ff <= vp_in; vp_idx_ff <= vp_idx_in; vp_age_ff <= vp_age_in;
      rsp <= rsp_in;
   end

   a_done_from_write: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == S_WRITE) else $error("done outside write");
   a_write_only_in_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == S_WRITE) else $error("stray ram write");
   a_write_hits_or_allocs: assert property (@(posedge clock) disable iff (reset)
      (ram_we && req_ff.operation == OP_SETBOND) |-> hit_ff)
      else $error("bond write to unknown slot");

endmodule

[rtl/device_record_table_top.sv]
// ---------------------------------------------------------------------------
// device_record_table_top
// Peer device record table keyed by a 48-bit address.
// ---------------------------------------------------------------------------
// Each request runs from accept to response beat as follows: the single-read
// record RAM is scanned one slot a cycle for a match, the lowest free slot and
// the oldest victims, then the target record is read again and, for add,
// lookup and a set-bond hit, written back, and the response takes two more
// register stages. One request is in flight at a time; the next request is
// taken once the output register is empty or its beat is being taken, so a
// stalled receiver stalls the input.
// No clearing pass: slot valid bits are flops cleared by reset.
module device_record_table_top import drt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    busy, done, start;
   rsp_type rsp;
   logic    we;
   logic [SLOT_W-1:0] waddr, raddr;
   rec_type wdata, rdata;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    done_ff;

   // hold off while busy or while a result beat is on its way or still waits
   assign req_stall = busy || done_ff || (rsp_valid_ff && rsp_stall);
   assign start     = req_valid && !req_stall;

   drt_scan u_scan (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .busy(busy), .done(done), .rsp(rsp),
      .ram_we(we), .ram_waddr(waddr), .ram_wdata(wdata),
      .ram_raddr(raddr), .ram_rdata(rdata)
   );

   drt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   // rsp from scan is registered at done, so the output register captures it under done_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done;
         if (done_ff) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (done_ff) rsp_data_ff <= rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the device record table: a directed table of
// requests followed by random traffic, mostly over a small address pool, every
// response beat checked against a predictor of the table in this file.
// ---------------------------------------------------------------------------
module tb_top import drt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 400;
   localparam int N_DIRECTED = 21;
   localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   device_record_table_top DUT (.*);

   always #4 clock = ~clock;

   // predictor copy of the table
   logic              tbl_valid [TABLE_ENTRIES];
   logic [47:0]       tbl_addr  [TABLE_ENTRIES];
   logic [31:0]       tbl_age   [TABLE_ENTRIES];
   logic              tbl_paired[TABLE_ENTRIES];
   logic              tbl_auth  [TABLE_ENTRIES];
   logic [7:0]        tbl_ktype [TABLE_ENTRIES];
   logic [1:0]        tbl_bond  [TABLE_ENTRIES];
   logic [31:0]       age_stamp;

   rsp_type expected_rsps[$];
   int errors = 0;
   int mismatches = 0;
   int send_idle_pct = 9;
   int recv_idle_pct = 60;
   bit hold_rsp = 1'b0;
   logic [47:0] addr_pool[8];

   // directed stimulus table
   req_type dir_req  [N_DIRECTED];
   rsp_type dir_want [N_DIRECTED];
   bit      dir_typed[N_DIRECTED];
   int      n_rows = 0;

   function automatic int find_entry(logic [47:0] a);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (tbl_valid[i] && tbl_addr[i] == a) return i;
      return -1;
   endfunction

   function automatic int pick_victim();
      int bu, bp;
      bu = -1;
      bp = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_paired[i]) begin
            if (bp < 0 || tbl_age[i] < tbl_age[bp]) bp = i;
         end else begin
            if (bu < 0 || tbl_age[i] < tbl_age[bu]) bu = i;
         end
      end
      return (bu >= 0) ? bu : bp;
   endfunction

   function automatic rsp_type predict_table(req_type r);
      rsp_type o;
      int s;
      bit show;
      o = '0;
      show = 1'b0;
      s = find_entry(r.peer_address);
      case (r.operation)
         OP_ADD, OP_LOOKUP: begin
            if (s >= 0) begin
               o.was_found = 1'b1;
               if (r.operation == OP_ADD) begin
                  tbl_age[s] = age_stamp;
                  age_stamp++;
                  tbl_bond[s] = BOND_UNKNOWN;
               end
            end else begin
               s = -1;
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (!tbl_valid[i] && s < 0) s = i;
               if (s < 0) begin
                  s = pick_victim();
                  o.did_evict = 1'b1;
                  o.evicted_address = tbl_addr[s];
               end
               tbl_valid[s] = 1'b1;
               tbl_addr[s] = r.peer_address;
               tbl_age[s] = age_stamp;
               age_stamp++;
               tbl_paired[s] = 1'b0;
               tbl_auth[s] = 1'b0;
               tbl_ktype[s] = '0;
               tbl_bond[s] = BOND_UNKNOWN;
            end
            if (r.operation == OP_ADD && r.has_link_key) begin
               tbl_paired[s] = 1'b1;
               tbl_ktype[s] = r.link_key_kind;
               if (r.pin_digits >= PIN_AUTH_MIN || r.link_key_kind == KEY_AUTH_A ||
                   r.link_key_kind == KEY_AUTH_B)
                  tbl_auth[s] = 1'b1;
            end
            show = 1'b1;
         end
         OP_DELETE: begin
            if (r.link_active) o.status = ST_REFUSED;
            else if (s >= 0) begin
               o.was_found = 1'b1;
               o.slot_index = s[3:0];
               tbl_valid[s] = 1'b0;
            end
         end
         default: begin
            if (s < 0) o.status = ST_UNKNOWN;
            else begin
               o.was_found = 1'b1;
               tbl_bond[s] = (r.new_bond_type == BOND_BAD) ? BOND_UNKNOWN
                                                            : r.new_bond_type;
               show = 1'b1;
            end
         end
      endcase
      if (show) begin
         o.slot_index = s[3:0];
         o.is_paired = tbl_paired[s];
         o.is_authenticated = tbl_auth[s];
         o.bond_kind = tbl_bond[s];
      end
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] op, logic [47:0] a, logic k,
                                        logic [7:0] kt, logic [4:0] pin,
                                        logic act, logic [1:0] bt);
      req_type r;
      r.operation = op;
      r.peer_address = a;
      r.has_link_key = k;
      r.link_key_kind = kt;
      r.pin_digits = pin;
      r.link_active = act;
      r.new_bond_type = bt;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type want);
      dir_req[n_rows] = r;
      dir_typed[n_rows] = typed;
      dir_want[n_rows] = want;
      n_rows++;
   endfunction

   // sends and queues the prediction; a typed-in row is checked against it
   task automatic run_req(req_type r, bit typed, rsp_type want);
      rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_table(r);
      if (typed && p != want) begin
         errors++;
         $display("directed row disagrees: typed %h predicted %h", want, p);
      end
      expected_rsps = {expected_rsps, p};
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_data);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               errors++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected st=%0d fnd=%0d slot=%0d ev=%0d ea=%h",
                     e.status, e.was_found, e.slot_index, e.did_evict,
                     e.evicted_address);
                  $display("          expected pr=%0d au=%0d bk=%0d",
                     e.is_paired, e.is_authenticated, e.bond_kind);
                  $display("          actual   st=%0d fnd=%0d slot=%0d ev=%0d ea=%h",
                     rsp_data.status, rsp_data.was_found, rsp_data.slot_index,
                     rsp_data.did_evict, rsp_data.evicted_address);
                  $display("          actual   pr=%0d au=%0d bk=%0d",
                     rsp_data.is_paired, rsp_data.is_authenticated, rsp_data.bond_kind);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic rsp_type zero_rsp(logic [1:0] st);
      rsp_type o;
      o = '0;
      o.status = st;
      return o;
   endfunction

   function automatic rsp_type new_rsp(int slot);
      rsp_type o;
      o = '0;
      o.slot_index = slot[3:0];
      return o;
   endfunction

   initial begin
      req_type r;
      int k;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0; tbl_addr[i] = '0; tbl_age[i] = '0;
         tbl_paired[i] = 1'b0; tbl_auth[i] = 1'b0; tbl_ktype[i] = '0; tbl_bond[i] = '0;
      end
      age_stamp = '0;
      for (int i = 0; i < 8; i++) addr_pool[i] = 48'({$urandom, $urandom});
      addr_pool[0] = '0;
      addr_pool[1] = ADDR_MAX;

      // empty table: refused delete, unknown delete, set on unknown
      add_row(make_req(OP_DELETE, 48'h0, 1'b0, 8'd0, 5'd0, 1'b1, 2'd0), 1'b1,
              zero_rsp(ST_REFUSED));
      add_row(make_req(OP_DELETE, ADDR_MAX, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b1,
              zero_rsp(ST_OK));
      add_row(make_req(OP_SETBOND, ADDR_MAX, 1'b0, 8'd0, 5'd0, 1'b0, 2'd1), 1'b1,
              zero_rsp(ST_UNKNOWN));
      // first allocations land in slots 0 and 1
      add_row(make_req(OP_LOOKUP, 48'h0, 1'b1, 8'hFF, 5'd31, 1'b1, 2'd3), 1'b1,
              new_rsp(0));
      add_row(make_req(OP_LOOKUP, ADDR_MAX, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b1,
              new_rsp(1));
      // keyed adds: pin 16, key type 5, key type 8, unauthenticated key; then an unkeyed add
      add_row(make_req(OP_ADD, ADDR_MAX, 1'b1, 8'd0, 5'd16, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_ADD, 48'h0, 1'b1, KEY_AUTH_A, 5'd0, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_ADD, 48'h123, 1'b1, KEY_AUTH_B, 5'd4, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_ADD, 48'h456, 1'b1, 8'hFF, 5'd15, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_ADD, 48'h789, 1'b0, 8'd5, 5'd31, 1'b0, 2'd0), 1'b0, '0);
      // bond codes, including the bad one, then add on a hit resets bond
      add_row(make_req(OP_SETBOND, 48'h0, 1'b0, 8'd0, 5'd0, 1'b0, 2'd1), 1'b0, '0);
      add_row(make_req(OP_SETBOND, 48'h123, 1'b0, 8'd0, 5'd0, 1'b0, 2'd2), 1'b0, '0);
      add_row(make_req(OP_SETBOND, ADDR_MAX, 1'b0, 8'd0, 5'd0, 1'b0, 2'd3), 1'b0, '0);
      add_row(make_req(OP_ADD, 48'h123, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_LOOKUP, 48'h456, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b0, '0);
      // delete with and without link
      add_row(make_req(OP_DELETE, 48'h456, 1'b0, 8'd0, 5'd0, 1'b1, 2'd0), 1'b1,
              zero_rsp(ST_REFUSED));
      add_row(make_req(OP_DELETE, 48'h456, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_SETBOND, 48'h456, 1'b0, 8'd0, 5'd0, 1'b0, 2'd1), 1'b1,
              zero_rsp(ST_UNKNOWN));
      add_row(make_req(OP_LOOKUP, 48'hABC, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b0, '0);
      add_row(make_req(OP_DELETE, 48'h0, 1'b1, 8'hFF, 5'd31, 1'b0, 2'd3), 1'b0, '0);
      add_row(make_req(OP_LOOKUP, 48'h0, 1'b0, 8'd0, 5'd0, 1'b0, 2'd0), 1'b0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) run_req(dir_req[i], dir_typed[i], dir_want[i]);

      // receiver holds off long while requests keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++)
            run_req(make_req(OP_LOOKUP, 48'({$urandom, $urandom}), 1'b0, 8'd0, 5'd0,
                             1'b0, 2'd0), 1'b0, '0);
      join

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 60 : 0;
         recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 9 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            r.operation = 2'($urandom_range(3));
            // small pool keeps hits frequent; a fresh address forces eviction once the table is full
            if ($urandom_range(99) < 25) r.peer_address = 48'({$urandom, $urandom});
            else r.peer_address = addr_pool[$urandom_range(7)] ^ 48'($urandom_range(3));
            r.has_link_key = 1'($urandom);
            r.link_key_kind = ($urandom_range(3) == 0) ? 8'(KEY_AUTH_A + 3 * $urandom_range(1))
                                                       : 8'($urandom);
            r.pin_digits = 5'($urandom_range(31));
            r.link_active = ($urandom_range(3) == 0);
            r.new_bond_type = 2'($urandom_range(3));
            run_req(r, 1'b0, '0);
         end
         // sender waits for the table to drain
         req_valid <= 1'b0;
         while (expected_rsps.size() != 0) @(posedge clock);
      end

      k = 0;
      while (expected_rsps.size() != 0 && k < 100000) begin
         @(posedge clock);
         k++;
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/drt_pkg.sv
rtl/drt_ram.sv
rtl/drt_scan.sv
rtl/device_record_table_top.sv
tb/sv/tb_top.sv
